// ===== design/escaped_frame_receiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared forms for the concurrent checks on the receiver ports.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define EFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Phase and status codes and register indexes shared by the receiver files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_ID    = 3'd1,
      PH_DEST  = 3'd2,
      PH_SRC   = 3'd3,
      PH_SIZE  = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHECK = 3'd6,
      PH_READY = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FRAME = 3'd1,
      ST_CHECK = 3'd2,
      ST_OVER  = 3'd3,
      ST_WAIT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_ESC_ENABLE = 3'd0,
      REG_START      = 3'd1,
      REG_ESC_CHAR   = 3'd2,
      REG_ESC_XOR    = 3'd3,
      REG_MAX_LOAD   = 3'd4
   } reg_index_type;

   localparam logic [7:0] SUM_INIT = 8'hFF;

endpackage

`default_nettype wire

// ===== design/escaped_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Deframes a byte-stuffed stream with header fields, payload and checksum.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word contents
//  req      in         tdata: data_byte; tuser: action
//  rsp      out        tdata: frame result fields; tuser: status
//  csr      in         register index and write data, always ready
//
// One word per cycle is accepted unless a held result stalls; the single result
// register sets this rate, and a result is in it in the cycle after its word.
// A new word is taken while the held result is being read out.
// Reset is synchronous and restores register defaults and an empty frame.
// A stalled result holds until taken and input stalls only behind it.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] payload_valid, [8:1] payload_index, [16:9] payload_byte,
   // [17] frame_done, [25:18] frame_id, [33:26] dest_address,
   // [41:34] source_address, [49:42] payload_size, [55:50] zero
   output logic [55:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic                 esc_enable_ff;
   logic [7:0]           start_ff;
   logic [7:0]           esc_char_ff;
   logic [7:0]           esc_xor_ff;
   logic [7:0]           max_load_ff;

   efr_pkg::phase_type   phase_ff, phase_in;
   logic                 pending_ff, pending_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           count_ff, count_in;
   logic [7:0]           length_ff, length_in;
   logic [7:0]           id_ff, id_in;
   logic [7:0]           dest_ff, dest_in;
   logic [7:0]           source_ff, source_in;

   efr_pkg::status_type  status_in;
   logic                 pvalid_in;
   logic [7:0]           pindex_in;
   logic [7:0]           pbyte_in;
   logic                 done_in;

   logic                 rsp_valid_ff;
   logic [55:0]          rsp_data_ff;
   logic [2:0]           rsp_user_ff;

   logic                 accept;
   logic [7:0]           byte_dec;
   logic                 pend_dec;
   logic                 is_esc;
   logic                 is_start;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_enable_ff <= 1'b0;
         start_ff      <= 8'h7E;
         esc_char_ff   <= 8'h7D;
         esc_xor_ff    <= 8'h20;
         max_load_ff   <= 8'hFF;
      end else if (csr_valid) begin
         case (efr_pkg::reg_index_type'(csr_index))
            efr_pkg::REG_ESC_ENABLE: esc_enable_ff <= csr_data[0];
            efr_pkg::REG_START:      start_ff      <= csr_data;
            efr_pkg::REG_ESC_CHAR:   esc_char_ff   <= csr_data;
            efr_pkg::REG_ESC_XOR:    esc_xor_ff    <= csr_data;
            efr_pkg::REG_MAX_LOAD:   max_load_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign is_esc   = esc_enable_ff && (req_tdata == esc_char_ff);
   assign is_start = esc_enable_ff && (req_tdata == start_ff);
   assign pend_dec = pending_ff && !esc_enable_ff;
   assign byte_dec = (esc_enable_ff && pending_ff) ? (req_tdata ^ esc_xor_ff) : req_tdata;

   always_comb begin
      phase_in  = phase_ff;
      pending_in = pending_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      length_in = length_ff;
      id_in     = id_ff;
      dest_in   = dest_ff;
      source_in = source_ff;
      status_in = efr_pkg::ST_OK;
      pvalid_in = 1'b0;
      pindex_in = 8'd0;
      pbyte_in  = 8'd0;
      done_in   = 1'b0;

      if (req_tuser) begin
         status_in = efr_pkg::ST_OK;
      end else if (phase_ff == efr_pkg::PH_READY) begin
         status_in = efr_pkg::ST_WAIT;
      end else if (is_esc) begin
         if (pending_ff) begin
            status_in = efr_pkg::ST_FRAME;
         end else begin
            pending_in = 1'b1;
         end
      end else if (is_start && phase_ff != efr_pkg::PH_START) begin
         status_in = efr_pkg::ST_FRAME;
      end else begin
         pending_in = pend_dec;
         case (phase_ff)
            efr_pkg::PH_START: begin
               if (byte_dec != start_ff) status_in = efr_pkg::ST_FRAME;
            end
            efr_pkg::PH_SIZE: begin
               if (byte_dec == 8'd0) status_in = efr_pkg::ST_FRAME;
            end
            efr_pkg::PH_DATA: begin
               if (count_ff == max_load_ff) status_in = efr_pkg::ST_OVER;
            end
            efr_pkg::PH_CHECK: begin
               if (byte_dec != sum_ff) status_in = efr_pkg::ST_CHECK;
            end
            default: ;
         endcase

         if (status_in == efr_pkg::ST_OK && !pend_dec) begin
            case (phase_ff)
               efr_pkg::PH_START: begin
                  sum_in   = efr_pkg::SUM_INIT;
                  phase_in = efr_pkg::PH_ID;
               end
               efr_pkg::PH_ID: begin
                  id_in    = byte_dec;
                  sum_in   = sum_ff - byte_dec;
                  phase_in = efr_pkg::PH_DEST;
               end
               efr_pkg::PH_DEST: begin
                  dest_in  = byte_dec;
                  sum_in   = sum_ff - byte_dec;
                  phase_in = efr_pkg::PH_SRC;
               end
               efr_pkg::PH_SRC: begin
                  source_in = byte_dec;
                  sum_in    = sum_ff - byte_dec;
                  phase_in  = efr_pkg::PH_SIZE;
               end
               efr_pkg::PH_SIZE: begin
                  count_in  = 8'd0;
                  length_in = byte_dec;
                  sum_in    = sum_ff - byte_dec;
                  phase_in  = efr_pkg::PH_DATA;
               end
               efr_pkg::PH_DATA: begin
                  pvalid_in = 1'b1;
                  pindex_in = count_ff;
                  pbyte_in  = byte_dec;
                  count_in  = count_ff + 8'd1;
                  sum_in    = sum_ff - byte_dec;
                  if (count_ff + 8'd1 == length_ff) phase_in = efr_pkg::PH_CHECK;
               end
               efr_pkg::PH_CHECK: begin
                  done_in  = 1'b1;
                  phase_in = efr_pkg::PH_READY;
               end
               default: begin
                  status_in = efr_pkg::ST_FRAME;
               end
            endcase
         end
      end

      if (req_tuser || (status_in != efr_pkg::ST_OK && status_in != efr_pkg::ST_WAIT)) begin
         phase_in   = efr_pkg::PH_START;
         pending_in = 1'b0;
         sum_in     = efr_pkg::SUM_INIT;
         count_in   = 8'd0;
         length_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= efr_pkg::PH_START;
         pending_ff <= 1'b0;
         sum_ff     <= efr_pkg::SUM_INIT;
         count_ff   <= 8'd0;
         length_ff  <= 8'd0;
         id_ff      <= 8'd0;
         dest_ff    <= 8'd0;
         source_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         id_ff      <= id_in;
         dest_ff    <= dest_in;
         source_ff  <= source_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {6'd0, length_in, source_in, dest_in, id_in, done_in,
                         pbyte_in, pindex_in, pvalid_in};
         rsp_user_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/efr_checker.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Port-level checks on the receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "escaped_frame_receiver_top_assert.svh"

module efr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index,
   input wire logic [7:0]  csr_data
);

   logic unused_in;

   assign unused_in = ^{req_tdata, req_tuser, csr_valid, csr_ready, csr_index, csr_data};

   // A held result does not change until it is read.
   `EFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // With no result pending, the receiver always takes a word.
   `EFR_ASSERT_SAME(a_ready_empty, clock, reset, !rsp_tvalid, req_tready)

   // An accepted word always shows a result in the next cycle.
   `EFR_ASSERT_NEXT(a_word_result, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // A payload byte or a completed frame reports a good status.
   `EFR_ASSERT_SAME(a_good_status, clock, reset, rsp_tvalid && (rsp_tdata[0] || rsp_tdata[17]), rsp_tuser == efr_pkg::ST_OK && !(rsp_tdata[0] && rsp_tdata[17]))

endmodule

bind escaped_frame_receiver_top efr_checker u_efr_checker (.*);

`default_nettype wire
